[src/msd_pkg.sv]
// shared types, constants and register indexes for the msd accumulator
package msd_pkg;

   localparam int MAX_ATOMS_DEF = 1024;
   localparam int LAG_BINS_DEF  = 64;

   localparam int POS_W   = 32;
   localparam int REF_W   = 3 * POS_W;
   localparam int SUM_W   = 64;
   localparam int CSR_AW  = 1;
   localparam int CSR_DW  = 32;

   localparam logic [CSR_AW-1:0] CSR_PBC_ENABLE = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_BOX_LENGTH = 1'd1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPARE = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [33:0] HALF_Q24 = 34'sd8388608;
   localparam logic signed [33:0] ONE_Q24  = 34'sd16777216;

   localparam logic [31:0] BOX_UNITY = 32'h0001_0000;

   typedef struct packed {
      logic               cmd;
      logic [9:0]         atom_index;
      logic [5:0]         lag;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } msd_req_type;

   typedef struct packed {
      logic [63:0] sq_disp;
      logic [63:0] bin_total;
      logic        saturated;
   } msd_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_SCALE,
      ST_SQUARE,
      ST_ACC,
      ST_BIN,
      ST_OUT
   } msd_state_type;

endpackage

[src/msd_min_image_accumulator.sv]
// msd accumulator top level: reference store, lag bins and shared arithmetic sequencer
// a load beat goes straight to out; no new beat is taken until the last one is through
// a compare beat runs diff, scale, square, acc per axis, then bin and out
// compare steps: scale and square multipliers shared by x, y and z, one pass per axis
// after reset the lag bins are zeroed, one per cycle, while req_ready stays low
// configuration registers reset to pbc off and a box length of 1.0
module msd_min_image_accumulator #(
   parameter int MAX_ATOMS = msd_pkg::MAX_ATOMS_DEF,
   parameter int LAG_BINS  = msd_pkg::LAG_BINS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  msd_pkg::msd_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output msd_pkg::msd_rsp_type         rsp_data,
   input  logic                         csr_we,
   input  logic [msd_pkg::CSR_AW-1:0]   csr_index,
   input  logic [msd_pkg::CSR_DW-1:0]   csr_wdata
);

   import msd_pkg::*;

   localparam int ATOM_AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int BIN_AW  = $clog2(LAG_BINS);
   localparam logic [BIN_AW-1:0] CLR_LAST = BIN_AW'(LAG_BINS - 1);

   msd_state_type state_ff, state_in;

   logic                pbc_ff;
   logic [31:0]         box_ff;
   logic [BIN_AW-1:0]   clr_ff;
   logic                rsp_valid_ff;
   msd_rsp_type         rsp_ff;

   msd_req_type         req_ff;
   logic [1:0]          axis_ff;
   logic [31:0]         mag_ff;
   logic [63:0]         prod_ff;
   logic [63:0]         sq_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    total_ff;
   logic                sat_ff;

   logic                accept;
   logic                out_free;
   logic                ref_we;
   logic                bin_we;
   logic                atom_ok;
   logic                lag_ok;
   logic [31:0]         req_atom_w;
   logic [31:0]         req_lag_w;
   logic [31:0]         item_lag_w;

   logic [REF_W-1:0]    ref_rdata;
   logic [SUM_W-1:0]    bin_rdata;
   logic [BIN_AW-1:0]   bin_waddr;
   logic [SUM_W-1:0]    bin_wdata;

   logic signed [31:0]  ref_sel;
   logic signed [31:0]  pos_sel;
   logic signed [33:0]  diff_w;
   logic signed [33:0]  wrap_w;
   logic signed [33:0]  neg_w;
   logic [31:0]         mag_w;
   logic [31:0]         mult_w;
   logic [63:0]         prod_w;
   logic [39:0]         comp40_w;
   logic                comp_sat;
   logic [31:0]         comp_w;
   logic [63:0]         sq_w;
   logic [SUM_W:0]      acc_w;
   logic [SUM_W:0]      bin_sum_w;
   logic [SUM_W-1:0]    bin_new_w;

   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_atom_w = 32'(req_data.atom_index);
   assign req_lag_w  = 32'(req_data.lag);
   assign item_lag_w = 32'(req_ff.lag);
   assign atom_ok    = req_atom_w < 32'(MAX_ATOMS);
   assign lag_ok     = item_lag_w < 32'(LAG_BINS);

   // reference and bin stores
   msd_ram #(
      .WIDTH (REF_W),
      .DEPTH (MAX_ATOMS)
   ) u_ref_ram (
      .clock (clock),
      .we    (ref_we),
      .waddr (req_atom_w[ATOM_AW-1:0]),
      .wdata ({req_data.pos_z, req_data.pos_y, req_data.pos_x}),
      .re    (accept),
      .raddr (req_atom_w[ATOM_AW-1:0]),
      .rdata (ref_rdata)
   );

   msd_ram #(
      .WIDTH (SUM_W),
      .DEPTH (LAG_BINS)
   ) u_bin_ram (
      .clock (clock),
      .we    (bin_we),
      .waddr (bin_waddr),
      .wdata (bin_wdata),
      .re    (accept),
      .raddr (req_lag_w[BIN_AW-1:0]),
      .rdata (bin_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_COMPARE && atom_ok) begin
                  state_in = ST_DIFF;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIFF:   state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACC;
         ST_ACC: begin
            if (axis_ff == AXIS_Z) begin
               state_in = ST_BIN;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_BIN: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      ref_we    = 1'b0;
      bin_we    = 1'b0;
      bin_waddr = item_lag_w[BIN_AW-1:0];
      bin_wdata = bin_new_w;
      case (state_ff)
         ST_CLEAR: begin
            bin_we    = 1'b1;
            bin_waddr = clr_ff;
            bin_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ref_we    = req_valid && req_data.cmd == CMD_LOAD && atom_ok;
         end
         ST_BIN: begin
            bin_we = lag_ok;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // per-axis datapath
   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            ref_sel = signed'(ref_rdata[POS_W-1:0]);
            pos_sel = req_ff.pos_x;
         end
         AXIS_Y: begin
            ref_sel = signed'(ref_rdata[2*POS_W-1:POS_W]);
            pos_sel = req_ff.pos_y;
         end
         default: begin
            ref_sel = signed'(ref_rdata[3*POS_W-1:2*POS_W]);
            pos_sel = req_ff.pos_z;
         end
      endcase
   end

   always_comb begin
      diff_w = 34'(ref_sel) - 34'(pos_sel);
      wrap_w = diff_w;
      if (pbc_ff) begin
         if (diff_w >= HALF_Q24) begin
            wrap_w = diff_w - ONE_Q24;
         end else if (diff_w < -HALF_Q24) begin
            wrap_w = diff_w + ONE_Q24;
         end
      end
      neg_w = -wrap_w;
      mag_w = (wrap_w < 0) ? neg_w[31:0] : wrap_w[31:0];
   end

   assign mult_w    = pbc_ff ? box_ff : BOX_UNITY;
   assign prod_w    = mag_ff * mult_w;
   assign comp40_w  = prod_ff[63:24];
   assign comp_sat  = |comp40_w[39:32];
   assign comp_w    = comp_sat ? '1 : comp40_w[31:0];
   assign sq_w      = comp_w * comp_w;
   assign acc_w     = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(sq_ff);
   assign bin_sum_w = (SUM_W + 1)'(bin_rdata) + (SUM_W + 1)'(sum_ff);
   assign bin_new_w = bin_sum_w[SUM_W] ? '1 : bin_sum_w[SUM_W-1:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pbc_ff       <= 1'b0;
         box_ff       <= BOX_UNITY;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PBC_ENABLE: pbc_ff <= csr_wdata[0];
               CSR_BOX_LENGTH: box_ff <= csr_wdata;
               default:        pbc_ff <= pbc_ff;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_data;
         axis_ff  <= AXIS_X;
         sum_ff   <= '0;
         total_ff <= '0;
         sat_ff   <= 1'b0;
      end
      case (state_ff)
         ST_DIFF:   mag_ff  <= mag_w;
         ST_SCALE:  prod_ff <= prod_w;
         ST_SQUARE: begin
            sq_ff <= sq_w;
            if (comp_sat) begin
               sat_ff <= 1'b1;
            end
         end
         ST_ACC: begin
            sum_ff  <= acc_w[SUM_W] ? '1 : acc_w[SUM_W-1:0];
            axis_ff <= axis_ff + 2'd1;
            if (acc_w[SUM_W]) begin
               sat_ff <= 1'b1;
            end
         end
         ST_BIN: begin
            if (lag_ok) begin
               total_ff <= bin_new_w;
               if (bin_sum_w[SUM_W]) begin
                  sat_ff <= 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_ff.sq_disp   <= sum_ff;
               rsp_ff.bin_total <= total_ff;
               rsp_ff.saturated <= sat_ff;
            end
         end
         default: begin
            mag_ff <= mag_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/msd_ram.sv]
// generic single write port, single read port ram with registered read
module msd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                    wdata,
   input  logic                                re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                    rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/msd_checker.sv]
// port-level checks for the msd accumulator, bound to the top level
module msd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input msd_pkg::msd_req_type       req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input msd_pkg::msd_rsp_type       rsp_data,
   input logic                       csr_we,
   input logic [msd_pkg::CSR_AW-1:0] csr_index,
   input logic [msd_pkg::CSR_DW-1:0] csr_wdata
);

   import msd_pkg::*;

   // a waiting result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped before it was taken");

   // one item at a time: no beat taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req beat taken while the previous one is in flight");

   // bin total never falls below the displacement it includes
   a_total_covers_sq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bin_total != 64'd0 |-> rsp_data.bin_total >= rsp_data.sq_disp)
      else $error("bin total below its own displacement");

   // after reset the bins are being cleared and nothing is offered
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ports active right after reset");

endmodule

bind msd_min_image_accumulator msd_checker u_msd_checker (.*);
